>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level to check its own logic
// each macro clocks on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain expression that must hold at every clock edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression that must never be true at a clock edge
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> rtl/yccd_pkg.sv
// shared constants, types and register codes of the 4:2:2 crop/decimate to rgb block
// no dependencies
`default_nettype none

package yccd_pkg;

  // largest source frame handled, larger settings are clamped
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // position counters and the wider compare path (pos + crop + step)
  localparam int POS_W = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
  localparam int CMP_W = POS_W + 4;

  // register file
  localparam int PADDR_W = 5;
  localparam int REG_W   = 32;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CROP_COLUMNS = 3'd2;
  localparam logic [2:0] REG_CROP_ROWS    = 3'd3;
  localparam logic [2:0] REG_PIXEL_STEP   = 3'd4;
  localparam logic [2:0] REG_FRAME_STEP   = 3'd5;
  localparam logic [2:0] REG_BYTE_ORDER   = 3'd6;

  // result queue
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // bt.601 integer coefficients
  localparam int PROD_W   = 20;
  localparam int COEF_Y   = 298;
  localparam int COEF_VR  = 409;
  localparam int COEF_UG  = 100;
  localparam int COEF_VG  = 208;
  localparam int COEF_UB  = 516;
  localparam int ROUND    = 128;
  localparam int Y_OFS    = 16;
  localparam int C_OFS    = 128;

  // one pixel handed to a conversion lane
  typedef struct packed {
    logic       row_end;
    logic       image_end;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } lane_in_t;

  // one converted result word
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
  } pix_t;

endpackage

`default_nettype wire

>>> rtl/yccd_rem.sv
// iterative remainder unit, one quotient bit per cycle, used to realign decimation phase
// depends on yccd_pkg
`default_nettype none

module yccd_rem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [yccd_pkg::POS_W-1:0] dividend,
  input  logic [7:0]                 divisor,
  output logic                       done,
  output logic [7:0]                 rem_out
);
  import yccd_pkg::*;

  localparam int ITER_W = $clog2(POS_W + 1);

  logic [POS_W-1:0]  q_r;
  logic [7:0]        r_r;
  logic [ITER_W-1:0] iter_r;
  logic              run_r;
  logic              done_r;
  logic [8:0]        r_try;
  logic [8:0]        r_sub;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    r_try = {r_r, q_r[POS_W-1]};
    r_sub = (r_try >= {1'b0, divisor}) ? (r_try - {1'b0, divisor}) : r_try;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      iter_r <= ITER_W'(POS_W);
    end else if (run_r) begin
      iter_r <= iter_r - ITER_W'(1);
      if (iter_r == ITER_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
    end else if (run_r) begin
      q_r <= {q_r[POS_W-2:0], 1'b0};
      r_r <= r_sub[7:0];
    end
  end

  assign done    = done_r;
  assign rem_out = r_r;

endmodule

`default_nettype wire

>>> rtl/yccd_lane.sv
// one color conversion lane: bt.601 products, then sum, round and clamp
// depends on yccd_pkg
`default_nettype none

module yccd_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_pick,
  input  yccd_pkg::lane_in_t in_data,
  output logic               out_pick,
  output yccd_pkg::pix_t     out_pix
);
  import yccd_pkg::*;

  logic signed [9:0]        c_s;
  logic signed [9:0]        d_s;
  logic signed [9:0]        e_s;
  logic                     a_pick_r;
  logic                     a_row_end_r;
  logic                     a_image_end_r;
  logic signed [PROD_W-1:0] a_y_r;
  logic signed [PROD_W-1:0] a_vr_r;
  logic signed [PROD_W-1:0] a_ug_r;
  logic signed [PROD_W-1:0] a_vg_r;
  logic signed [PROD_W-1:0] a_ub_r;
  logic signed [PROD_W-1:0] r_t;
  logic signed [PROD_W-1:0] g_t;
  logic signed [PROD_W-1:0] b_t;
  logic                     b_pick_r;
  pix_t                     b_pix_r;

  // clamp a rounded sum to one byte after dropping the fraction
  function automatic logic [7:0] sat_byte(input logic signed [PROD_W-1:0] t);
    logic [7:0] res;
    if (t < 0) begin
      res = 8'd0;
    end else if (t[PROD_W-2:16] != '0) begin
      res = 8'd255;
    end else begin
      res = t[15:8];
    end
    return res;
  endfunction

  // remove offsets
  always_comb begin
    c_s = $signed({2'b00, in_data.y}) - 10'(Y_OFS);
    d_s = $signed({2'b00, in_data.u}) - 10'(C_OFS);
    e_s = $signed({2'b00, in_data.v}) - 10'(C_OFS);
  end

  // stage a: constant products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_pick_r <= 1'b0;
    end else begin
      a_pick_r <= in_pick;
    end
  end

  always_ff @(posedge clk) begin
    a_row_end_r   <= in_data.row_end;
    a_image_end_r <= in_data.image_end;
    a_y_r         <= PROD_W'(c_s) * PROD_W'(COEF_Y);
    a_vr_r        <= PROD_W'(e_s) * PROD_W'(COEF_VR);
    a_ug_r        <= PROD_W'(d_s) * PROD_W'(COEF_UG);
    a_vg_r        <= PROD_W'(e_s) * PROD_W'(COEF_VG);
    a_ub_r        <= PROD_W'(d_s) * PROD_W'(COEF_UB);
  end

  // stage b: sums with rounding
  always_comb begin
    r_t = a_y_r + a_vr_r + PROD_W'(ROUND);
    g_t = a_y_r - a_ug_r - a_vg_r + PROD_W'(ROUND);
    b_t = a_y_r + a_ub_r + PROD_W'(ROUND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_pick_r <= 1'b0;
    end else begin
      b_pick_r <= a_pick_r;
    end
  end

  always_ff @(posedge clk) begin
    b_pix_r.red       <= sat_byte(r_t);
    b_pix_r.green     <= sat_byte(g_t);
    b_pix_r.blue      <= sat_byte(b_t);
    b_pix_r.row_end   <= a_row_end_r;
    b_pix_r.image_end <= a_image_end_r;
  end

  assign out_pick = b_pick_r;
  assign out_pix  = b_pix_r;

endmodule

`default_nettype wire

>>> rtl/yccd_merge.sv
// merges the two lane outputs, left pixel first, into one result queue
// depends on yccd_pkg
`default_nettype none

module yccd_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push0,
  input  yccd_pkg::pix_t             pix0,
  input  logic                       push1,
  input  yccd_pkg::pix_t             pix1,
  output logic                       out_valid,
  input  logic                       out_ready,
  output yccd_pkg::pix_t             out_pix,
  output logic [yccd_pkg::CNT_W-1:0] count
);
  import yccd_pkg::*;

  pix_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] wr1;
  logic [1:0]       n_push;
  logic             pop;

  always_comb begin
    wr1    = wr_r + PTR_W'(push0);
    n_push = {1'b0, push0} + {1'b0, push1};
    pop    = out_valid & out_ready;
  end

  // queue storage, lane 0 lands ahead of lane 1
  always_ff @(posedge clk) begin
    if (push0) begin
      mem_r[wr_r] <= pix0;
    end
    if (push1) begin
      mem_r[wr1] <= pix1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(n_push);
      rd_r  <= rd_r + PTR_W'(pop);
      cnt_r <= cnt_r + CNT_W'(n_push) - CNT_W'(pop);
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_pix   = mem_r[rd_r];
  assign count     = cnt_r;

endmodule

`default_nettype wire

>>> rtl/yuv422_crop_decimate_to_rgb.sv
// top level: register file, frame/row/column tracking, pick logic, two lanes and merge
// depends on yccd_pkg, yccd_rem, yccd_lane, yccd_merge and assert_macros.svh
//
// Takes one packed 4:2:2 macropixel (UYVY or YUYV) per word and returns zero, one or two
// RGB888 words, left pixel first, for the pixels kept after frame skipping, border crop
// and decimation. An input word is taken every clock while the result queue has room
// and no realignment runs; one result leaves per clock while out_ready is high, so with
// pixel_step at one inside a used frame the output port limits the input rate, otherwise
// one word per clock. From input to the first result a word passes the pick register, the
// product stage, the sum/clamp stage and the result queue. Each register write realigns
// the decimation phase with a 12-step remainder unit run twice, with in_ready held low.
`default_nettype none
`include "assert_macros.svh"

module yuv422_crop_decimate_to_rgb (
  input  logic                         clk,
  input  logic                         rst_n,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yccd_pkg::PADDR_W-1:0] paddr,
  input  logic [yccd_pkg::REG_W-1:0]   pwdata,
  output logic [yccd_pkg::REG_W-1:0]   prdata,
  output logic                         pready,
  // macropixel input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte_zero,
  input  logic [7:0]                   in_byte_one,
  input  logic [7:0]                   in_byte_two,
  input  logic [7:0]                   in_byte_three,
  input  logic                         in_frame_last,
  // rgb output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_red,
  output logic [7:0]                   out_green,
  output logic [7:0]                   out_blue,
  output logic                         out_row_end,
  output logic                         out_image_end
);
  import yccd_pkg::*;

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_LOAD = 2'd1;
  localparam logic [1:0] RS_ROW  = 2'd2;
  localparam logic [1:0] RS_COL  = 2'd3;
  localparam int         CRED_W  = CNT_W + 1;

  // registers
  logic [12:0]      fw_r;
  logic [12:0]      fh_r;
  logic [10:0]      cc_r;
  logic [10:0]      cr_r;
  logic [7:0]       ps_r;
  logic [7:0]       fs_r;
  logic             bo_r;
  logic             cfg_wr;
  logic [2:0]       reg_idx;

  // tracking state
  logic [POS_W-1:0] col_pos_r;
  logic [POS_W-1:0] row_pos_r;
  logic [CMP_W-1:0] nc_r;
  logic [CMP_W-1:0] nr_r;
  logic [7:0]       fc_r;
  logic             taken_r;
  logic [1:0]       rs_state_r;
  logic [1:0]       rs_state_nxt;

  // derived values
  logic [7:0]       dstep;
  logic [7:0]       fstep;
  logic [CMP_W-1:0] d_w;
  logic [CMP_W-1:0] w_eff;
  logic [CMP_W-1:0] h_eff;
  logic [CMP_W-1:0] crc_w;
  logic [CMP_W-1:0] crr_w;
  logic [CMP_W-1:0] first_c;
  logic [CMP_W-1:0] first_r;
  logic [CMP_W-1:0] p0;
  logic [CMP_W-1:0] p1;
  logic [CMP_W-1:0] rw;
  logic             m0;
  logic             m1;
  logic             in0;
  logic             in1;
  logic             last0;
  logic             last1;
  logic             row_hit;
  logic             row_last;
  logic             frame_start;
  logic [7:0]       fc_inc;
  logic             take;
  logic             taken_now;
  logic             pick0;
  logic             pick1;
  logic [CMP_W-1:0] nc_adv;
  logic [CMP_W-1:0] col_sum;
  logic [CMP_W-1:0] row_sum;
  logic             col_wrap;
  logic             row_wrap;
  logic             frame_done;
  logic [POS_W-1:0] col_pos_nxt;
  logic [POS_W-1:0] row_pos_nxt;
  logic [CMP_W-1:0] nc_nxt;
  logic [CMP_W-1:0] nr_nxt;
  logic [7:0]       fc_nxt;
  logic             accept;
  logic             busy;

  // phase realignment
  logic             row_ge;
  logic             col_ge;
  logic [POS_W-1:0] row_x;
  logic [POS_W-1:0] col_x;
  logic             rem_start;
  logic [POS_W-1:0] rem_x;
  logic             rem_done;
  logic [7:0]       rem_val;
  logic [CMP_W-1:0] adj;

  // pick stage and credit
  logic             s1_pick0_r;
  logic             s1_pick1_r;
  lane_in_t         s1_lane0_r;
  lane_in_t         s1_lane1_r;
  logic [1:0]       pend_a_r;
  logic [1:0]       pend_b_r;
  logic [1:0]       pend_s1;
  logic [CRED_W-1:0] credit_need;

  // lane outputs and queue
  logic             l0_pick;
  logic             l1_pick;
  pix_t             l0_pix;
  pix_t             l1_pix;
  pix_t             head_pix;
  logic [CNT_W-1:0] fifo_cnt;

  // register port decode
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= 13'd640;
      fh_r <= 13'd480;
      cc_r <= '0;
      cr_r <= '0;
      ps_r <= 8'd1;
      fs_r <= 8'd1;
      bo_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  fw_r <= pwdata[12:0];
        REG_FRAME_HEIGHT: fh_r <= pwdata[12:0];
        REG_CROP_COLUMNS: cc_r <= pwdata[10:0];
        REG_CROP_ROWS:    cr_r <= pwdata[10:0];
        REG_PIXEL_STEP:   ps_r <= pwdata[7:0];
        REG_FRAME_STEP:   fs_r <= pwdata[7:0];
        REG_BYTE_ORDER:   bo_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = REG_W'(fw_r);
      REG_FRAME_HEIGHT: prdata = REG_W'(fh_r);
      REG_CROP_COLUMNS: prdata = REG_W'(cc_r);
      REG_CROP_ROWS:    prdata = REG_W'(cr_r);
      REG_PIXEL_STEP:   prdata = REG_W'(ps_r);
      REG_FRAME_STEP:   prdata = REG_W'(fs_r);
      REG_BYTE_ORDER:   prdata = REG_W'(bo_r);
      default:          prdata = '0;
    endcase
  end

  // effective settings: zero steps act as one, oversized frames are clamped
  always_comb begin
    dstep   = (ps_r == 8'd0) ? 8'd1 : ps_r;
    fstep   = (fs_r == 8'd0) ? 8'd1 : fs_r;
    d_w     = CMP_W'(dstep);
    w_eff   = (CMP_W'(fw_r) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(fw_r);
    h_eff   = (CMP_W'(fh_r) > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : CMP_W'(fh_r);
    crc_w   = CMP_W'(cc_r);
    crr_w   = CMP_W'(cr_r);
    first_c = crc_w + CMP_W'(dstep[7:1]);
    first_r = crr_w + CMP_W'(dstep[7:1]);
  end

  // pick decision for the two pixels of the current word
  always_comb begin
    p0       = CMP_W'(col_pos_r);
    p1       = p0 + CMP_W'(1);
    rw       = CMP_W'(row_pos_r);
    m0       = (p0 == nc_r);
    m1       = (p1 == nc_r) | (m0 & (dstep == 8'd1));
    in0      = (p0 + crc_w) < w_eff;
    in1      = (p1 + crc_w) < w_eff;
    last0    = (p0 + d_w + crc_w) >= w_eff;
    last1    = (p1 + d_w + crc_w) >= w_eff;
    row_hit  = (rw == nr_r) & ((rw + crr_w) < h_eff);
    row_last = (rw + d_w + crr_w) >= h_eff;

    frame_start = (col_pos_r == '0) & (row_pos_r == '0);
    fc_inc      = fc_r + 8'd1;
    take        = fc_inc >= fstep;
    taken_now   = frame_start ? take : taken_r;
    fc_nxt      = frame_start ? (take ? 8'd0 : fc_inc) : fc_r;

    pick0 = taken_now & row_hit & m0 & in0;
    pick1 = taken_now & row_hit & m1 & in1;
  end

  // position advance and phase tracking
  always_comb begin
    nc_adv     = (m0 & m1) ? (nc_r + CMP_W'(2)) : ((m0 | m1) ? (nc_r + d_w) : nc_r);
    col_sum    = p0 + CMP_W'(2);
    row_sum    = rw + CMP_W'(1);
    col_wrap   = col_sum >= w_eff;
    row_wrap   = row_sum >= h_eff;
    frame_done = in_frame_last | (col_wrap & row_wrap);

    col_pos_nxt = (frame_done | col_wrap) ? '0 : col_sum[POS_W-1:0];
    row_pos_nxt = frame_done ? '0 : (col_wrap ? row_sum[POS_W-1:0] : row_pos_r);
    nc_nxt      = (frame_done | col_wrap) ? first_c : nc_adv;
    nr_nxt      = frame_done ? first_r : ((col_wrap & (rw == nr_r)) ? (nr_r + d_w) : nr_r);
  end

  // realignment operands: distance past the first kept position
  always_comb begin
    row_ge    = rw >= first_r;
    col_ge    = p0 >= first_c;
    row_x     = row_ge ? POS_W'(rw - first_r) : '0;
    col_x     = col_ge ? POS_W'(p0 - first_c) : '0;
    rem_start = (rs_state_r == RS_LOAD) | ((rs_state_r == RS_ROW) & rem_done);
    rem_x     = (rs_state_r == RS_LOAD) ? row_x : col_x;
    adj       = (rem_val == 8'd0) ? '0 : (d_w - CMP_W'(rem_val));
  end

  yccd_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_x),
    .divisor  (dstep),
    .done     (rem_done),
    .rem_out  (rem_val)
  );

  // realignment sequencer, restarted by every register write
  always_comb begin
    rs_state_nxt = rs_state_r;
    if (cfg_wr) begin
      rs_state_nxt = RS_LOAD;
    end else begin
      unique case (rs_state_r)
        RS_IDLE: rs_state_nxt = RS_IDLE;
        RS_LOAD: rs_state_nxt = RS_ROW;
        RS_ROW:  rs_state_nxt = rem_done ? RS_COL : RS_ROW;
        RS_COL:  rs_state_nxt = rem_done ? RS_IDLE : RS_COL;
        default: rs_state_nxt = RS_IDLE;
      endcase
    end
  end

  assign busy = (rs_state_r != RS_IDLE);

  // input flow control: no realignment running and room in the queue for everything in flight plus two
  always_comb begin
    pend_s1     = {1'b0, s1_pick0_r} + {1'b0, s1_pick1_r};
    credit_need = CRED_W'(fifo_cnt) + CRED_W'(pend_s1) + CRED_W'(pend_a_r)
                + CRED_W'(pend_b_r) + CRED_W'(2);
    in_ready    = !busy && (credit_need <= CRED_W'(FIFO_DEPTH));
    accept      = in_valid & in_ready;
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_state_r <= RS_IDLE;
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      nc_r       <= '0;
      nr_r       <= '0;
      fc_r       <= '0;
      taken_r    <= 1'b0;
    end else begin
      rs_state_r <= rs_state_nxt;
      if (accept) begin
        col_pos_r <= col_pos_nxt;
        row_pos_r <= row_pos_nxt;
        nc_r      <= nc_nxt;
        nr_r      <= nr_nxt;
        fc_r      <= fc_nxt;
        taken_r   <= taken_now;
      end else if (!cfg_wr && rem_done && (rs_state_r == RS_ROW)) begin
        nr_r <= row_ge ? (rw + adj) : first_r;
      end else if (!cfg_wr && rem_done && (rs_state_r == RS_COL)) begin
        nc_r <= col_ge ? (p0 + adj) : first_c;
      end
    end
  end

  // pick stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_pick0_r <= 1'b0;
      s1_pick1_r <= 1'b0;
      pend_a_r   <= '0;
      pend_b_r   <= '0;
    end else begin
      s1_pick0_r <= accept & pick0;
      s1_pick1_r <= accept & pick1;
      pend_a_r   <= pend_s1;
      pend_b_r   <= pend_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_lane0_r.row_end   <= last0;
      s1_lane0_r.image_end <= last0 & row_last;
      s1_lane0_r.y         <= bo_r ? in_byte_zero : in_byte_one;
      s1_lane0_r.u         <= bo_r ? in_byte_one : in_byte_zero;
      s1_lane0_r.v         <= bo_r ? in_byte_three : in_byte_two;
      s1_lane1_r.row_end   <= last1;
      s1_lane1_r.image_end <= last1 & row_last;
      s1_lane1_r.y         <= bo_r ? in_byte_two : in_byte_three;
      s1_lane1_r.u         <= bo_r ? in_byte_one : in_byte_zero;
      s1_lane1_r.v         <= bo_r ? in_byte_three : in_byte_two;
    end
  end

  // conversion lanes, left and right pixel
  yccd_lane u_lane0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pick  (s1_pick0_r),
    .in_data  (s1_lane0_r),
    .out_pick (l0_pick),
    .out_pix  (l0_pix)
  );

  yccd_lane u_lane1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pick  (s1_pick1_r),
    .in_data  (s1_lane1_r),
    .out_pick (l1_pick),
    .out_pix  (l1_pix)
  );

  // result queue
  yccd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (l0_pick),
    .pix0      (l0_pix),
    .push1     (l1_pick),
    .pix1      (l1_pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (head_pix),
    .count     (fifo_cnt)
  );

  assign out_red       = head_pix.red;
  assign out_green     = head_pix.green;
  assign out_blue      = head_pix.blue;
  assign out_row_end   = head_pix.row_end;
  assign out_image_end = head_pix.image_end;

  // checks
  `ASSERT_CLK(a_fifo_bound, fifo_cnt <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `ASSERT_CLK(a_wr_blocks_in, cfg_wr |=> !in_ready, "word taken right after a register write")
  `ASSERT_CLK(a_two_picks, (s1_pick0_r && s1_pick1_r) |-> (dstep == 8'd1), "two picks with step above one")
  `ASSERT_CLK(a_col_phase, !busy |-> (nc_r >= p0), "next kept column behind current column")

endmodule

`default_nettype wire

>>> verif/tb_yuv422_crop_decimate_to_rgb.sv
// testbench for the 4:2:2 crop/decimate to rgb block: directed and random macropixel streams
// depends on yccd_pkg and the rtl top yuv422_crop_decimate_to_rgb
// expected rgb words come from a local frame/row/column tracker with bt.601 conversion
module tb_yuv422_crop_decimate_to_rgb;
  timeunit 1ns;
  timeprecision 1ps;
  import yccd_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 10;
  localparam bit ORDER_UYVY    = 1'b0;
  localparam bit ORDER_YUYV    = 1'b1;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]   pwdata = '0;
  logic [REG_W-1:0]   prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_byte_zero = '0;
  logic [7:0]         in_byte_one = '0;
  logic [7:0]         in_byte_two = '0;
  logic [7:0]         in_byte_three = '0;
  logic               in_frame_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               out_row_end;
  logic               out_image_end;

  // register shadow, indexed by register code
  logic [31:0] cfg_shadow [8];
  logic [2:0]  all_regs [7] = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CROP_COLUMNS,
                                REG_CROP_ROWS, REG_PIXEL_STEP, REG_FRAME_STEP,
                                REG_BYTE_ORDER};

  // tracker state of the stream
  int   frames_seen = 0;
  bit   frame_used = 1'b0;
  int   col_at = 0;
  int   row_at = 0;

  pix_t rgb_expected [$];
  int   words_sent = 0;
  int   rgb_due = 0;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   feed_gaps = 1'b0;
  bit   drain_stalls = 1'b0;

  yuv422_crop_decimate_to_rgb uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_zero (in_byte_zero),
    .in_byte_one  (in_byte_one),
    .in_byte_two  (in_byte_two),
    .in_byte_three(in_byte_three),
    .in_frame_last(in_frame_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_row_end  (out_row_end),
    .out_image_end(out_image_end)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL yuv422_crop_decimate_to_rgb");
      $finish;
    end
  end

  // output back-pressure: mostly ready, short and occasional long stalls
  always @(negedge clk) begin : sink_pacing
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) stall_left--;
    else if (drain_stalls && roll >= 70)
      stall_left = (roll >= 96) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    out_ready <= (stall_left == 0);
  end

  function automatic logic [31:0] field_mask(logic [2:0] code);
    case (code)
      REG_FRAME_WIDTH, REG_FRAME_HEIGHT: return 32'h1FFF;
      REG_CROP_COLUMNS, REG_CROP_ROWS:   return 32'h07FF;
      REG_PIXEL_STEP, REG_FRAME_STEP:    return 32'h00FF;
      REG_BYTE_ORDER:                    return 32'h0001;
      default:                           return 32'h0;
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return $urandom_range(0, 255);
  endfunction

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drop the fraction and clamp to 0..255
  function automatic logic [7:0] to_byte(int t);
    if (t < 0) return 8'd0;
    t = t >> 8;
    return (t > 255) ? 8'd255 : t[7:0];
  endfunction

  // kept position on one axis after crop and decimation
  function automatic bit on_grid(int pos, int size, int crop, int step, output bit at_last);
    int first;
    int lim;
    at_last = 1'b0;
    first = crop + step / 2;
    lim = size - crop;
    if (pos < first || pos >= lim) return 1'b0;
    if ((pos - first) % step != 0) return 1'b0;
    at_last = (pos + step >= lim);
    return 1'b1;
  endfunction

  // expected rgb words of one macropixel, advances the tracker
  function automatic void predict_rgb(logic [7:0] b0, b1, b2, b3, logic mark_end);
    int   w;
    int   h;
    int   step;
    int   fstep;
    int   crop_c;
    int   crop_r;
    int   cb;
    int   cr;
    int   c;
    int   dd;
    int   e;
    int   luma [2];
    bit   row_keep;
    bit   row_last;
    bit   col_last;
    pix_t px;
    w = (cfg_shadow[REG_FRAME_WIDTH] > MAX_WIDTH) ? MAX_WIDTH
        : int'(cfg_shadow[REG_FRAME_WIDTH]);
    h = (cfg_shadow[REG_FRAME_HEIGHT] > MAX_HEIGHT) ? MAX_HEIGHT
        : int'(cfg_shadow[REG_FRAME_HEIGHT]);
    step = (cfg_shadow[REG_PIXEL_STEP] == 0) ? 1 : int'(cfg_shadow[REG_PIXEL_STEP]);
    fstep = (cfg_shadow[REG_FRAME_STEP] == 0) ? 1 : int'(cfg_shadow[REG_FRAME_STEP]);
    crop_c = int'(cfg_shadow[REG_CROP_COLUMNS]);
    crop_r = int'(cfg_shadow[REG_CROP_ROWS]);

    // frame start decides whether this frame is used
    if (col_at == 0 && row_at == 0) begin
      frames_seen = (frames_seen + 1) % 256;
      frame_used = (frames_seen >= fstep);
      if (frame_used) frames_seen = 0;
    end

    if (cfg_shadow[REG_BYTE_ORDER][0] == ORDER_UYVY) begin
      cb = b0; luma[0] = b1; cr = b2; luma[1] = b3;
    end else begin
      luma[0] = b0; cb = b1; luma[1] = b2; cr = b3;
    end

    row_keep = on_grid(row_at, h, crop_r, step, row_last);
    for (int k = 0; k < 2; k++) begin
      if (frame_used && row_keep && on_grid(col_at + k, w, crop_c, step, col_last)) begin
        c = luma[k] - 16;
        dd = cb - 128;
        e = cr - 128;
        px.red = to_byte(298 * c + 409 * e + 128);
        px.green = to_byte(298 * c - 100 * dd - 208 * e + 128);
        px.blue = to_byte(298 * c + 516 * dd + 128);
        px.row_end = col_last;
        px.image_end = col_last && row_last;
        rgb_expected.push_back(px);
        rgb_due++;
      end
    end

    // advance position, wrap at line and frame end
    col_at += 2;
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
      if (row_at >= h) row_at = 0;
    end
    if (mark_end) begin
      col_at = 0;
      row_at = 0;
    end
  endfunction

  task automatic compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    pix_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rgb_expected.size() == 0) begin
        $display("%0t: unexpected word, expected none, got rgb %0d %0d %0d ends %0d %0d",
                 $time, out_red, out_green, out_blue, out_row_end, out_image_end);
        mismatch_count++;
      end else begin
        want = rgb_expected.pop_front();
        compare_field("red", want.red, out_red);
        compare_field("green", want.green, out_green);
        compare_field("blue", want.blue, out_blue);
        compare_field("row_end", want.row_end, out_row_end);
        compare_field("image_end", want.image_end, out_image_end);
      end
    end
  end

  task automatic reg_write(logic [2:0] code, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {code, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_shadow[code] = value & field_mask(code);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(logic [2:0] code);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {code, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== cfg_shadow[code]) begin
      $display("%0t: register %0d readback mismatch, expected %0d, got %0d",
               $time, code, cfg_shadow[code], prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // stop feeding, let every expected word arrive, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame_config(int fw, int fh, int cc, int cr, int ps, int fs, bit order);
    wait_idle();
    reg_write(REG_FRAME_WIDTH, fw);
    reg_write(REG_FRAME_HEIGHT, fh);
    reg_write(REG_CROP_COLUMNS, cc);
    reg_write(REG_CROP_ROWS, cr);
    reg_write(REG_PIXEL_STEP, ps);
    reg_write(REG_FRAME_STEP, fs);
    reg_write(REG_BYTE_ORDER, order);
  endtask

  // one macropixel word, after an optional gap
  task automatic send_word(input logic [7:0] b0, b1, b2, b3, input logic mark_end);
    int gap;
    gap = pick_gap(feed_gaps);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_zero <= b0;
    in_byte_one <= b1;
    in_byte_two <= b2;
    in_byte_three <= b3;
    in_frame_last <= mark_end;
    do @(posedge clk); while (!in_ready);
    predict_rgb(b0, b1, b2, b3, mark_end);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_words(int count, bit mark_end);
    for (int i = 0; i < count; i++)
      send_word(rand_byte(), rand_byte(), rand_byte(), rand_byte(),
                mark_end && (i == count - 1));
  endtask

  // reset values, then all-ones and all-zero writes read back
  task automatic test_register_access();
    foreach (all_regs[i]) reg_check(all_regs[i]);
    foreach (all_regs[i]) reg_write(all_regs[i], 32'hFFFF_FFFF);
    foreach (all_regs[i]) reg_check(all_regs[i]);
    foreach (all_regs[i]) reg_write(all_regs[i], 32'h0);
    foreach (all_regs[i]) reg_check(all_regs[i]);
  endtask

  // clamping at both ends and both byte orders, every pixel kept
  task automatic test_color_extremes();
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    set_frame_config(4, 2, 0, 0, 1, 1, ORDER_UYVY);
    send_word(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    send_word(8'd128, 8'd16, 8'd128, 8'd235, 1'b0);
    send_word(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    set_frame_config(4, 2, 0, 0, 1, 1, ORDER_YUYV);
    send_word(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_word(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_word(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0);
    send_word(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
  endtask

  // border crop with decimation, row and image end marks
  task automatic test_crop_and_step();
    feed_gaps = 1'b1;
    drain_stalls = 1'b0;
    set_frame_config(6, 4, 1, 1, 2, 1, ORDER_UYVY);
    send_random_words(12, 1'b0);
    drain_stalls = 1'b1;
    set_frame_config(8, 6, 0, 0, 3, 1, ORDER_YUYV);
    send_random_words(24, 1'b0);
  endtask

  // frame_last before the last kept line gives no image end
  task automatic test_early_frame_last();
    feed_gaps = 1'b0;
    drain_stalls = 1'b1;
    set_frame_config(6, 4, 0, 0, 1, 1, ORDER_UYVY);
    send_random_words(5, 1'b1);
    send_random_words(12, 1'b0);
  endtask

  // odd width, zero and tiny sizes
  task automatic test_odd_and_zero_sizes();
    feed_gaps = 1'b1;
    drain_stalls = 1'b0;
    set_frame_config(5, 2, 0, 0, 1, 1, ORDER_UYVY);
    send_random_words(6, 1'b0);
    set_frame_config(0, 0, 0, 0, 1, 1, ORDER_YUYV);
    send_random_words(3, 1'b0);
    set_frame_config(1, 1, 0, 0, 1, 1, ORDER_UYVY);
    send_random_words(2, 1'b0);
  endtask

  // zero pixel and frame step act as one
  task automatic test_zero_steps();
    feed_gaps = 1'b0;
    drain_stalls = 1'b1;
    set_frame_config(4, 2, 0, 0, 0, 0, ORDER_UYVY);
    send_random_words(4, 1'b0);
  endtask

  // crop that leaves nothing
  task automatic test_crop_too_large();
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    set_frame_config(4, 2, 2047, 0, 1, 1, ORDER_UYVY);
    send_random_words(4, 1'b0);
    set_frame_config(4, 2, 0, 2047, 1, 1, ORDER_UYVY);
    send_random_words(4, 1'b0);
  endtask

  // one frame in three, then one in 255, single-word frames
  task automatic test_frame_skip();
    feed_gaps = 1'b1;
    drain_stalls = 1'b1;
    set_frame_config(2, 1, 0, 0, 1, 3, ORDER_UYVY);
    send_random_words(9, 1'b0);
    feed_gaps = 1'b0;
    set_frame_config(2, 1, 0, 0, 1, 255, ORDER_YUYV);
    send_random_words(512, 1'b0);
  endtask

  // largest pixel step: a single kept pixel per frame
  task automatic test_widest_step();
    feed_gaps = 1'b0;
    drain_stalls = 1'b1;
    set_frame_config(128, 128, 0, 0, 255, 1, ORDER_UYVY);
    send_random_words(64 * 128, 1'b0);
  endtask

  // width and height above the maximum act as the maximum
  task automatic test_oversized_frame();
    feed_gaps = 1'b0;
    drain_stalls = 1'b1;
    set_frame_config(8191, 3, 2047, 0, 1, 1, ORDER_UYVY);
    send_random_words(2049, 1'b1);
    set_frame_config(2, 8191, 0, 2047, 1, 1, ORDER_YUYV);
    send_random_words(2050, 1'b1);
  endtask

  // random settings, mostly well-formed frames, some cut short or left open
  task automatic test_random_frames();
    int words_start;
    int rgb_start;
    int fw;
    int fh;
    int cc;
    int cr;
    int ps;
    int fs;
    int per_line;
    int lines;
    int span;
    int mode;
    bit mark;
    bit fl;
    words_start = words_sent;
    rgb_start = rgb_due;
    while (words_sent - words_start < 750 || rgb_due - rgb_start < 60) begin
      fw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 24);
      fh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 12);
      cc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 3);
      cr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 3);
      ps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 4);
      fs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 3);
      set_frame_config(fw, fh, cc, cr, ps, fs, $urandom_range(0, 1));
      feed_gaps = ($urandom_range(0, 3) != 0);
      drain_stalls = ($urandom_range(0, 3) != 0);
      per_line = ((fw > MAX_WIDTH ? MAX_WIDTH : fw) + 1) / 2;
      if (per_line == 0) per_line = 1;
      lines = (fh > MAX_HEIGHT) ? MAX_HEIGHT : fh;
      if (lines == 0) lines = 1;
      repeat ($urandom_range(2, 4)) begin
        span = per_line * lines;
        mode = $urandom_range(0, 9);
        mark = (mode != 1);
        // long frames are cut short with frame_last
        if (span > 120) begin
          span = $urandom_range(20, 120);
          mark = 1'b1;
        end else if (mode == 0) begin
          span = $urandom_range(1, span);
        end
        for (int i = 0; i < span; i++) begin
          fl = mark && (i == span - 1);
          if ($urandom_range(0, 59) == 0) fl = 1'b1;
          send_word(rand_byte(), rand_byte(), rand_byte(), rand_byte(), fl);
        end
      end
    end
  endtask

  initial begin
    cfg_shadow[REG_FRAME_WIDTH] = 640;
    cfg_shadow[REG_FRAME_HEIGHT] = 480;
    cfg_shadow[REG_CROP_COLUMNS] = 0;
    cfg_shadow[REG_CROP_ROWS] = 0;
    cfg_shadow[REG_PIXEL_STEP] = 1;
    cfg_shadow[REG_FRAME_STEP] = 1;
    cfg_shadow[REG_BYTE_ORDER] = ORDER_UYVY;
    cfg_shadow[7] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_color_extremes();
    test_crop_and_step();
    test_early_frame_last();
    test_odd_and_zero_sizes();
    test_zero_steps();
    test_crop_too_large();
    test_frame_skip();
    test_widest_step();
    test_oversized_frame();
    test_random_frames();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS yuv422_crop_decimate_to_rgb");
    end else begin
      $display("FAIL yuv422_crop_decimate_to_rgb");
    end
    $finish;
  end

endmodule
